// ----- rtl/twt_pkg.sv -----
// shared types and constants for the timing wheel timer pool
package twt_pkg;

	localparam int POOL_SIZE = 32;
	localparam int IDX_W     = 5;
	localparam int SLOT_W    = 6;
	localparam int ROT_W     = 25;
	localparam int TAG_W     = 32;
	localparam int IV_W      = 16;

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [2:0] KIND_ADDED    = 3'd0;
	localparam logic [2:0] KIND_ADD_REJ  = 3'd1;
	localparam logic [2:0] KIND_DELETED  = 3'd2;
	localparam logic [2:0] KIND_DEL_FREE = 3'd3;
	localparam logic [2:0] KIND_EXPIRED  = 3'd4;
	localparam logic [2:0] KIND_DONE     = 3'd5;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] timeout;
		logic [4:0]         handle;
		logic [31:0]        user_tag;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  timer_handle;
		logic [31:0] expired_tag;
		logic [5:0]  slot_now;
		logic        last;
	} out_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [SLOT_W-1:0] slot;
		logic [ROT_W-1:0]  rot;
		logic [TAG_W-1:0]  tag;
	} wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} del_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} free_t;

	typedef struct packed {
		logic             expire;
		logic [IDX_W-1:0] idx;
		logic [TAG_W-1:0] tag;
	} scan_t;

endpackage

// ----- rtl/timing_wheel_timer_pool_core.sv -----
// top level of the timing wheel timer pool
// add: result put once the 32-step bit-serial 32 by 16 divider is done; delete: result
// put from ST_DEL; tick: done result after the scan token walks the 32-cell chain
// one entry per cycle while no expiry waits on the output; one command at a time,
// the next accepted in the cycle after the last put
// reset clears all entry valid bits, the current slot and sets the interval to 1
module timing_wheel_timer_pool_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  twt_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output twt_pkg::out_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data
);
	import twt_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_DEL  = 3'd3;
	localparam logic [2:0] ST_TICK = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]        st_q;
	in_t               req_q;
	logic [IV_W-1:0]   iv_q;
	logic [SLOT_W-1:0] cur_q;
	logic              out_valid_q;
	out_t              out_q;

	logic              in_acc;
	logic              can_put;
	logic              put;
	out_t              put_data;
	logic              div_start;
	logic              div_done;
	logic [31:0]       quo;
	logic [31:0]       ticks;
	logic              start_tick;
	logic              adv;
	logic              shift;
	wr_t               wr;
	del_t              del;
	logic              del_hit;

	logic  [POOL_SIZE:0] tok;
	free_t [POOL_SIZE:0] fre;
	scan_t [POOL_SIZE:0] scn;
	logic  [POOL_SIZE-1:0] valid_vec;

	assign in_ready  = (st_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign can_put   = !out_valid_q || out_ready;

	assign div_start  = in_acc && in_data.cmd == CMD_ADD;
	assign start_tick = in_acc && in_data.cmd == CMD_TICK;

	twt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_data.timeout),
		.divisor  ((iv_q == '0) ? IV_W'(1) : iv_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign tok[0] = start_tick;
	assign fre[0] = '0;
	assign scn[0] = '0;

	assign adv   = !scn[POOL_SIZE].expire || can_put;
	assign shift = start_tick || (st_q == ST_TICK && adv);

	genvar g;
	generate
		for (g = 0; g < POOL_SIZE; g++) begin : g_cell
			twt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cell_idx   (IDX_W'(g)),
				.wr         (wr),
				.del        (del),
				.wheel_slot (cur_q),
				.shift      (shift),
				.tok_in     (tok[g]),
				.tok_out    (tok[g+1]),
				.valid_out  (valid_vec[g]),
				.free_in    (fre[g]),
				.free_out   (fre[g+1]),
				.scan_in    (scn[g]),
				.scan_out   (scn[g+1])
			);
		end
	endgenerate

	assign ticks   = (quo == '0) ? 32'd1 : quo;
	assign del_hit = valid_vec[req_q.handle];

	always_comb begin
		put      = 1'b0;
		put_data = '0;
		wr       = '0;
		del      = '0;
		wr.idx   = fre[POOL_SIZE].idx;
		wr.slot  = cur_q + ticks[SLOT_W-1:0];
		wr.rot   = ticks[SLOT_W +: ROT_W];
		wr.tag   = req_q.user_tag;
		del.idx  = req_q.handle;
		unique case (st_q)
			ST_ADD: begin
				if (can_put) begin
					put           = 1'b1;
					put_data.last = 1'b1;
					if (req_q.timeout[31] || !fre[POOL_SIZE].found) begin
						put_data.kind = KIND_ADD_REJ;
					end else begin
						put_data.kind         = KIND_ADDED;
						put_data.timer_handle = fre[POOL_SIZE].idx;
						wr.en                 = 1'b1;
					end
				end
			end
			ST_DEL: begin
				if (can_put) begin
					put                   = 1'b1;
					put_data.last         = 1'b1;
					put_data.timer_handle = req_q.handle;
					del.en                = del_hit;
					put_data.kind         = del_hit ? KIND_DELETED : KIND_DEL_FREE;
				end
			end
			ST_TICK: begin
				if (scn[POOL_SIZE].expire && can_put) begin
					put                   = 1'b1;
					put_data.kind         = KIND_EXPIRED;
					put_data.timer_handle = scn[POOL_SIZE].idx;
					put_data.expired_tag  = scn[POOL_SIZE].tag;
					put_data.slot_now     = cur_q;
				end
			end
			ST_DONE: begin
				if (can_put) begin
					put               = 1'b1;
					put_data.kind     = KIND_DONE;
					put_data.slot_now = cur_q;
					put_data.last     = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			iv_q        <= IV_W'(1);
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				iv_q <= cfg_data;
			if (put)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_data.cmd)
							CMD_ADD:  st_q <= ST_DIV;
							CMD_DEL:  st_q <= ST_DEL;
							CMD_TICK: st_q <= ST_TICK;
							default:  st_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIV:  if (div_done) st_q <= ST_ADD;
				ST_ADD:  if (put) st_q <= ST_IDLE;
				ST_DEL:  if (put) st_q <= ST_IDLE;
				ST_TICK: if (shift && tok[POOL_SIZE]) st_q <= ST_DONE;
				ST_DONE: begin
					if (put) begin
						st_q  <= ST_IDLE;
						cur_q <= cur_q + SLOT_W'(1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			req_q <= in_data;
		if (put)
			out_q <= put_data;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ----- rtl/twt_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module twt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [twt_pkg::IV_W-1:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import twt_pkg::*;

	logic [IV_W:0]   rem_q;
	logic [31:0]     quo_q;
	logic [IV_W-1:0] dsr_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [IV_W:0]   rem_sh;
	logic            ge;

	assign rem_sh = {rem_q[IV_W-1:0], quo_q[31]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- rtl/twt_cell.sv -----
// one timer entry of the pool with its scan token and chain links
module twt_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [twt_pkg::IDX_W-1:0]  cell_idx,
	input  twt_pkg::wr_t             wr,
	input  twt_pkg::del_t            del,
	input  logic [twt_pkg::SLOT_W-1:0] wheel_slot,
	input  logic                     shift,
	input  logic                     tok_in,
	output logic                     tok_out,
	output logic                     valid_out,
	input  twt_pkg::free_t           free_in,
	output twt_pkg::free_t           free_out,
	input  twt_pkg::scan_t           scan_in,
	output twt_pkg::scan_t           scan_out
);
	import twt_pkg::*;

	logic              valid_q;
	logic              tok_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ROT_W-1:0]  rot_q;
	logic [TAG_W-1:0]  tag_q;
	logic              hit;
	logic              exp_now;

	assign hit     = tok_q && valid_q && (slot_q == wheel_slot);
	assign exp_now = hit && (rot_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			if (shift)
				tok_q <= tok_in;
			if (wr.en && wr.idx == cell_idx)
				valid_q <= 1'b1;
			else if (del.en && del.idx == cell_idx)
				valid_q <= 1'b0;
			else if (shift && exp_now)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == cell_idx) begin
			slot_q <= wr.slot;
			rot_q  <= wr.rot;
			tag_q  <= wr.tag;
		end else if (shift && hit && !exp_now) begin
			rot_q <= rot_q - ROT_W'(1);
		end
	end

	assign tok_out   = tok_q;
	assign valid_out = valid_q;

	always_comb begin
		free_out = free_in;
		if (!free_in.found && !valid_q) begin
			free_out.found = 1'b1;
			free_out.idx   = cell_idx;
		end
		scan_out = scan_in;
		if (exp_now) begin
			scan_out.expire = 1'b1;
			scan_out.idx    = cell_idx;
			scan_out.tag    = tag_q;
		end
	end
endmodule
